// ===== rtl/mapt_pkg.sv =====
// ----------------------------------------------------------------------------
// mapt_pkg - shared definitions of the moving average position trader
// widths, codes, state encoding and the control structs between the blocks
// ----------------------------------------------------------------------------
`default_nettype none

package mapt_pkg;

   localparam int WINDOW_DEPTH_DEF = 1024;

   localparam int PRICE_W    = 32;
   localparam int PERIOD_W   = 11;
   localparam int SUM_W      = PRICE_W + PERIOD_W;
   localparam int QUO_W      = 32;
   localparam int BAL_W      = 48;
   localparam int COUNT_W    = 32;
   localparam int ACTION_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE  = 2'd0,
      ACT_OPEN  = 2'd1,
      ACT_CLOSE = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_PERIOD = 2'd0,
      CSR_LONG_PERIOD  = 2'd1,
      CSR_SPREAD       = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DECIDE,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic update;
   } win_ctrl_type;

   typedef struct packed {
      logic [SUM_W-1:0]    short_sum;
      logic [SUM_W-1:0]    long_sum;
      logic [PERIOD_W-1:0] ns;
      logic [PERIOD_W-1:0] nl;
   } win_stat_type;

endpackage

`default_nettype wire

// ===== rtl/mapt_if.sv =====
// ----------------------------------------------------------------------------
// mapt_if - channel interfaces of the moving average position trader
// price input, result output and register write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface mapt_req_if;
   logic                         valid;
   logic                         ready;
   logic [mapt_pkg::PRICE_W-1:0] price;

   modport source (output valid, output price, input ready);
   modport sink   (input valid, input price, output ready);
endinterface

interface mapt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mapt_pkg::ACTION_W-1:0]       action;
   logic [mapt_pkg::QUO_W-1:0]          short_avg;
   logic [mapt_pkg::QUO_W-1:0]          long_avg;
   logic signed [mapt_pkg::BAL_W-1:0]   balance;
   logic [mapt_pkg::COUNT_W-1:0]        open_count;
   logic [mapt_pkg::COUNT_W-1:0]        close_count;

   modport source (output valid, output action, output short_avg, output long_avg,
                   output balance, output open_count, output close_count, input ready);
   modport sink   (input valid, input action, input short_avg, input long_avg,
                   input balance, input open_count, input close_count, output ready);
endinterface

interface mapt_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mapt_pkg::CSR_IDX_W-1:0]  index;
   logic [mapt_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mapt_window.sv =====
// ----------------------------------------------------------------------------
// mapt_window - price window memory with running short and long sums
// circular buffer, one write and two eviction reads per transaction
// ----------------------------------------------------------------------------
`default_nettype none

module mapt_window #(
   parameter int WINDOW_DEPTH = mapt_pkg::WINDOW_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mapt_pkg::win_ctrl_type          ctrl,
   input  wire logic [mapt_pkg::PRICE_W-1:0]    price,
   input  wire logic [mapt_pkg::PERIOD_W-1:0]   eff_s,
   input  wire logic [mapt_pkg::PERIOD_W-1:0]   eff_l,
   output      mapt_pkg::win_stat_type          stat
);

   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int PW    = mapt_pkg::PERIOD_W;
   localparam int SW    = mapt_pkg::SUM_W;

   logic [mapt_pkg::PRICE_W-1:0] window_ff [WINDOW_DEPTH];
   logic [mapt_pkg::PRICE_W-1:0] rd_short_ff, rd_long_ff, price_ff;

   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PW-1:0]    fill_ff, fill_in;
   logic [PW-1:0]    ns_ff, ns_in, nl_ff;
   logic             evict_s_ff, evict_l_ff;
   logic [SW-1:0]    short_sum_ff, short_sum_in, long_sum_ff, long_sum_in;

   logic [PTR_W-1:0] addr_s, addr_l;
   logic [31:0]      back_s, back_l;

   // entries that leave the short and long windows sit s and l slots back
   always_comb begin
      back_s = 32'(wp_ff) + 32'(WINDOW_DEPTH) - 32'(eff_s);
      back_l = 32'(wp_ff) + 32'(WINDOW_DEPTH) - 32'(eff_l);
      addr_s = (back_s >= 32'(WINDOW_DEPTH)) ? PTR_W'(back_s - 32'(WINDOW_DEPTH))
                                              : PTR_W'(back_s);
      addr_l = (back_l >= 32'(WINDOW_DEPTH)) ? PTR_W'(back_l - 32'(WINDOW_DEPTH))
                                              : PTR_W'(back_l);
      wp_in   = (32'(wp_ff) + 32'd1 >= 32'(WINDOW_DEPTH)) ? '0 : wp_ff + PTR_W'(1);
      fill_in = (fill_ff < eff_l) ? fill_ff + PW'(1) : eff_l;
      ns_in   = (eff_s < fill_in) ? eff_s : fill_in;
      short_sum_in = short_sum_ff + SW'(price_ff) - (evict_s_ff ? SW'(rd_short_ff) : '0);
      long_sum_in  = long_sum_ff + SW'(price_ff) - (evict_l_ff ? SW'(rd_long_ff) : '0);
   end

   // read before write: a full window of the memory depth evicts the slot written now
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         window_ff[wp_ff] <= price;
         rd_short_ff      <= window_ff[addr_s];
         rd_long_ff       <= window_ff[addr_l];
         price_ff         <= price;
         evict_s_ff       <= (fill_ff >= eff_s);
         evict_l_ff       <= (fill_ff >= eff_l);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         wp_ff        <= '0;
         fill_ff      <= '0;
         ns_ff        <= '0;
         nl_ff        <= '0;
         short_sum_ff <= '0;
         long_sum_ff  <= '0;
      end else begin
         if (ctrl.push) begin
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
            ns_ff   <= ns_in;
            nl_ff   <= fill_in;
         end
         if (ctrl.update) begin
            short_sum_ff <= short_sum_in;
            long_sum_ff  <= long_sum_in;
         end
      end
   end

   assign stat.short_sum = short_sum_ff;
   assign stat.long_sum  = long_sum_ff;
   assign stat.ns        = ns_ff;
   assign stat.nl        = nl_ff;

endmodule

`default_nettype wire

// ===== rtl/mapt_div.sv =====
// ----------------------------------------------------------------------------
// mapt_div - serial restoring divider for the window averages
// one quotient bit per cycle, quotient known to fit the price width
// ----------------------------------------------------------------------------
`default_nettype none

module mapt_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [mapt_pkg::SUM_W-1:0]     dividend,
   input  wire logic [mapt_pkg::PERIOD_W-1:0]  divisor,
   output      logic                           busy,
   output      logic [mapt_pkg::QUO_W-1:0]     quotient
);

   localparam int PW  = mapt_pkg::PERIOD_W;
   localparam int QW  = mapt_pkg::QUO_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic [PW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [PW-1:0]    div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [PW:0]      trial;
   logic             ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[QW-1]};
      ge     = (trial >= {1'b0, div_ff});
      rem_in = ge ? PW'(trial - {1'b0, div_ff}) : PW'(trial);
      quo_in = {quo_ff[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(QW);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[mapt_pkg::SUM_W-1:QW];
         quo_ff <= dividend[QW-1:0];
         div_ff <= divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/moving_average_position_trader_unit.sv =====
// ----------------------------------------------------------------------------
// moving_average_position_trader_unit - moving average price cross trader
// one price in, one trade decision with averages, balance and counts out
// ----------------------------------------------------------------------------
// Each price transaction runs through the states idle, sum, decide, div and
// out. The accepting edge reads the two evicted window entries from the price
// memory, the next edge updates the running sums and the price times period
// product, the next one makes the open or close decision and starts the two
// serial dividers, which then work at one quotient bit per cycle. Once both
// dividers finish, the out state loads the output register as soon as it is
// free. A new price is taken the cycle after the result is loaded into the
// output register, even if it has not been taken yet, so a price is only
// accepted once the one before it is through. While a result waits in the
// output register the next one stalls when done and the input stays closed.
// Any write of the short or long period register empties the window;
// position, balance and counts are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_position_trader_unit #(
   parameter int WINDOW_DEPTH = mapt_pkg::WINDOW_DEPTH_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   mapt_req_if.sink    req_bus,
   mapt_rsp_if.source  rsp_bus,
   mapt_csr_if.sink    csr_bus
);

   localparam int PW  = mapt_pkg::PERIOD_W;
   localparam int SW  = mapt_pkg::SUM_W;
   localparam int BW  = mapt_pkg::BAL_W;
   localparam int BW1 = mapt_pkg::BAL_W + 1;
   localparam int DW  = mapt_pkg::PRICE_W + 2;
   localparam int CW  = mapt_pkg::COUNT_W;
   localparam logic [BW-1:0] BAL_MAX = {1'b0, {(BW-1){1'b1}}};
   localparam logic [BW-1:0] BAL_MIN = {1'b1, {(BW-1){1'b0}}};

   mapt_pkg::state_type    state_ff, state_in;
   mapt_pkg::win_ctrl_type win_ctrl;
   mapt_pkg::win_stat_type win_stat;
   mapt_pkg::action_type   action_ff, action_in;

   logic [PW-1:0]                   short_len_ff, long_len_ff;
   logic [mapt_pkg::PRICE_W-1:0]    spread_ff;
   logic [mapt_pkg::PRICE_W-1:0]    price_ff, entry_price_ff, entry_price_in;
   logic                            position_open_ff, position_open_in;
   logic [BW-1:0]                   balance_ff, balance_in;
   logic [CW-1:0]                   opens_ff, opens_in, closes_ff, closes_in;
   logic [SW-1:0]                   prod_ff, prod_in;

   logic                            rsp_valid_ff;
   mapt_pkg::action_type            rsp_action_ff;
   logic [mapt_pkg::QUO_W-1:0]      rsp_short_avg_ff, rsp_long_avg_ff;
   logic [BW-1:0]                   rsp_balance_ff;
   logic [CW-1:0]                   rsp_opens_ff, rsp_closes_ff;

   logic [PW-1:0]                   eff_s, eff_l;
   logic                            req_accept, csr_accept, period_write;
   logic                            div_start, rsp_load, out_free;
   logic                            avg_above;
   logic                            short_busy, long_busy;
   logic [mapt_pkg::QUO_W-1:0]      short_quo, long_quo;
   logic signed [DW-1:0]            delta;
   logic signed [BW1-1:0]           bal_sum;

   // effective periods
   always_comb begin
      if (long_len_ff == '0) begin
         eff_l = PW'(1);
      end else if (32'(long_len_ff) > 32'(WINDOW_DEPTH)) begin
         eff_l = PW'(WINDOW_DEPTH);
      end else begin
         eff_l = long_len_ff;
      end
      if (short_len_ff == '0) begin
         eff_s = PW'(1);
      end else if (short_len_ff > eff_l) begin
         eff_s = eff_l;
      end else begin
         eff_s = short_len_ff;
      end
   end

   assign req_accept   = req_bus.valid && req_bus.ready;
   assign csr_accept   = csr_bus.valid && csr_bus.ready;
   assign period_write = csr_accept && ((csr_bus.index == mapt_pkg::CSR_SHORT_PERIOD) ||
                                        (csr_bus.index == mapt_pkg::CSR_LONG_PERIOD));
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         short_len_ff <= PW'(1);
         long_len_ff  <= PW'(1);
         spread_ff    <= '0;
      end else if (csr_accept) begin
         case (csr_bus.index)
            mapt_pkg::CSR_SHORT_PERIOD: short_len_ff <= csr_bus.data[PW-1:0];
            mapt_pkg::CSR_LONG_PERIOD:  long_len_ff  <= csr_bus.data[PW-1:0];
            mapt_pkg::CSR_SPREAD:       spread_ff    <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mapt_pkg::ST_IDLE:   if (req_accept) state_in = mapt_pkg::ST_SUM;
         mapt_pkg::ST_SUM:    state_in = mapt_pkg::ST_DECIDE;
         mapt_pkg::ST_DECIDE: state_in = mapt_pkg::ST_DIV;
         mapt_pkg::ST_DIV:    if (!short_busy && !long_busy) state_in = mapt_pkg::ST_OUT;
         mapt_pkg::ST_OUT:    if (out_free) state_in = mapt_pkg::ST_IDLE;
         default:             state_in = mapt_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_bus.ready   = 1'b0;
      div_start       = 1'b0;
      rsp_load        = 1'b0;
      win_ctrl.update = 1'b0;
      unique case (state_ff)
         mapt_pkg::ST_IDLE:   req_bus.ready   = 1'b1;
         mapt_pkg::ST_SUM:    win_ctrl.update = 1'b1;
         mapt_pkg::ST_DECIDE: div_start       = 1'b1;
         mapt_pkg::ST_DIV:    ;
         mapt_pkg::ST_OUT:    rsp_load        = out_free;
         default:             ;
      endcase
      win_ctrl.clear = period_write;
      win_ctrl.push  = req_accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mapt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   mapt_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .ctrl  (win_ctrl),
      .price (req_bus.price),
      .eff_s (eff_s),
      .eff_l (eff_l),
      .stat  (win_stat)
   );

   assign prod_in = SW'(price_ff) * SW'(win_stat.ns);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         price_ff <= req_bus.price;
      end
      if (state_ff == mapt_pkg::ST_SUM) begin
         prod_ff <= prod_in;
      end
   end

   // trade decision
   always_comb begin
      avg_above        = (win_stat.short_sum > prod_ff);
      delta            = $signed({2'b00, price_ff}) - $signed({2'b00, entry_price_ff})
                         - $signed({2'b00, spread_ff});
      bal_sum          = BW1'($signed(balance_ff)) + BW1'(delta);
      action_in        = mapt_pkg::ACT_NONE;
      position_open_in = position_open_ff;
      entry_price_in   = entry_price_ff;
      balance_in       = balance_ff;
      opens_in         = opens_ff;
      closes_in        = closes_ff;
      if (!position_open_ff && !avg_above) begin
         action_in        = mapt_pkg::ACT_OPEN;
         position_open_in = 1'b1;
         entry_price_in   = price_ff;
         if (opens_ff != '1) opens_in = opens_ff + CW'(1);
      end else if (position_open_ff && avg_above) begin
         action_in        = mapt_pkg::ACT_CLOSE;
         position_open_in = 1'b0;
         if (bal_sum[BW] != bal_sum[BW-1]) begin
            balance_in = bal_sum[BW] ? BAL_MIN : BAL_MAX;
         end else begin
            balance_in = bal_sum[BW-1:0];
         end
         if (closes_ff != '1) closes_in = closes_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_open_ff <= 1'b0;
         entry_price_ff   <= '0;
         balance_ff       <= '0;
         opens_ff         <= '0;
         closes_ff        <= '0;
         action_ff        <= mapt_pkg::ACT_NONE;
      end else if (state_ff == mapt_pkg::ST_DECIDE) begin
         position_open_ff <= position_open_in;
         entry_price_ff   <= entry_price_in;
         balance_ff       <= balance_in;
         opens_ff         <= opens_in;
         closes_ff        <= closes_in;
         action_ff        <= action_in;
      end
   end

   mapt_div u_short_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (win_stat.short_sum),
      .divisor  (win_stat.ns),
      .busy     (short_busy),
      .quotient (short_quo)
   );

   mapt_div u_long_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (win_stat.long_sum),
      .divisor  (win_stat.nl),
      .busy     (long_busy),
      .quotient (long_quo)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_action_ff    <= action_ff;
         rsp_short_avg_ff <= short_quo;
         rsp_long_avg_ff  <= long_quo;
         rsp_balance_ff   <= balance_ff;
         rsp_opens_ff     <= opens_ff;
         rsp_closes_ff    <= closes_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.action      = rsp_action_ff;
   assign rsp_bus.short_avg   = rsp_short_avg_ff;
   assign rsp_bus.long_avg    = rsp_long_avg_ff;
   assign rsp_bus.balance     = $signed(rsp_balance_ff);
   assign rsp_bus.open_count  = rsp_opens_ff;
   assign rsp_bus.close_count = rsp_closes_ff;

`ifndef SYNTHESIS
   a_short_within_long: assert property (@(posedge clock) disable iff (reset)
      win_stat.ns <= win_stat.nl)
      else $error("short window count exceeds long window count");

   a_short_sum_subset: assert property (@(posedge clock) disable iff (reset)
      state_ff == mapt_pkg::ST_DECIDE |-> win_stat.short_sum <= win_stat.long_sum)
      else $error("short sum larger than long sum");

   a_result_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == mapt_pkg::ST_OUT && !$past(short_busy))
      else $error("result raised outside the output step");

   a_close_needs_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == mapt_pkg::ST_DECIDE && action_in == mapt_pkg::ACT_CLOSE
      |-> position_open_ff ##1 !position_open_ff)
      else $error("close without an open position");
`endif

endmodule

`default_nettype wire

// ===== sim/trade_result_checker.sv =====
// ----------------------------------------------------------------------------
// trade_result_checker - result predictor and scoreboard of the trader unit
// watches the price, result and register channels, keeps its own copy of the
// price window, the averages, the position and the balance, and compares every
// result transaction field by field with the oldest expected outcome
// ----------------------------------------------------------------------------
`default_nettype none

module trade_result_checker (
   input  wire logic clock,
   input  wire logic reset,
   mapt_req_if       req_mon,
   mapt_rsp_if       rsp_mon,
   mapt_csr_if       csr_mon,
   output int        fail_count,
   output int        pending
);

   localparam int DEPTH  = mapt_pkg::WINDOW_DEPTH_DEF;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int PRC_W  = mapt_pkg::PRICE_W;
   localparam int PER_W  = mapt_pkg::PERIOD_W;
   localparam int AVG_W  = mapt_pkg::QUO_W;
   localparam int BALW   = mapt_pkg::BAL_W;
   localparam int CNT_W  = mapt_pkg::COUNT_W;
   localparam longint BALANCE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint BALANCE_MIN = -BALANCE_MAX - 64'sd1;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      mapt_pkg::action_type action;
      logic [AVG_W-1:0]     short_avg;
      logic [AVG_W-1:0]     long_avg;
      logic [BALW-1:0]      balance;
      logic [CNT_W-1:0]     opens;
      logic [CNT_W-1:0]     closes;
   } trade_outcome_type;

   logic [PRC_W-1:0]      recent_prices [DEPTH];
   logic [SLOT_W-1:0]     head;
   int unsigned           filled;
   logic [PER_W-1:0]      short_setting;
   logic [PER_W-1:0]      long_setting;
   logic [PRC_W-1:0]      spread_setting;
   logic                  in_position;
   logic [PRC_W-1:0]      entry_level;
   longint                balance_acc;
   logic [CNT_W-1:0]      opens;
   logic [CNT_W-1:0]      closes;
   trade_outcome_type     expected_q [$];

   function automatic trade_outcome_type apply_price(input logic [PRC_W-1:0] price);
      int unsigned       long_len;
      int unsigned       short_len;
      int unsigned       n_short;
      int unsigned       n_long;
      int unsigned       k;
      logic [63:0]       short_total;
      logic [63:0]       long_total;
      logic [SLOT_W-1:0] slot;
      logic              avg_above;
      longint            next_bal;
      trade_outcome_type r;

      long_len = (long_setting == 0) ? 1 : long_setting;
      if (long_len > DEPTH) long_len = DEPTH;
      short_len = (short_setting == 0) ? 1 : short_setting;
      if (short_len > long_len) short_len = long_len;

      recent_prices[head] = price;
      head = head + 1'b1;
      if (filled < long_len) filled++;
      if (filled > long_len) filled = long_len;
      n_short = (short_len < filled) ? short_len : filled;
      n_long = filled;

      short_total = 64'd0;
      long_total = 64'd0;
      slot = head;
      for (k = 0; k < n_long; k++) begin
         slot = slot - 1'b1;
         long_total += 64'(recent_prices[slot]);
         if (k < n_short) short_total += 64'(recent_prices[slot]);
      end

      avg_above = short_total > 64'(price) * 64'(n_short);
      r.action = mapt_pkg::ACT_NONE;
      if (!in_position && !avg_above) begin
         r.action = mapt_pkg::ACT_OPEN;
         in_position = 1'b1;
         entry_level = price;
         if (opens != COUNT_MAX) opens++;
      end else if (in_position && avg_above) begin
         next_bal = balance_acc + longint'(64'(price)) - longint'(64'(entry_level))
                    - longint'(64'(spread_setting));
         if (next_bal > BALANCE_MAX) next_bal = BALANCE_MAX;
         if (next_bal < BALANCE_MIN) next_bal = BALANCE_MIN;
         balance_acc = next_bal;
         r.action = mapt_pkg::ACT_CLOSE;
         in_position = 1'b0;
         if (closes != COUNT_MAX) closes++;
      end

      r.short_avg = AVG_W'(short_total / 64'(n_short));
      r.long_avg = AVG_W'(long_total / 64'(n_long));
      r.balance = balance_acc[BALW-1:0];
      r.opens = opens;
      r.closes = closes;
      return r;
   endfunction

   function automatic int check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      trade_outcome_type want;
      int errs;

      errs = 0;
      if (reset) begin
         head = '0;
         filled = 0;
         short_setting = 11'd1;
         long_setting = 11'd1;
         spread_setting = '0;
         in_position = 1'b0;
         entry_level = '0;
         balance_acc = 0;
         opens = '0;
         closes = '0;
         expected_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (mapt_pkg::csr_index_type'(csr_mon.index))
               mapt_pkg::CSR_SHORT_PERIOD: begin
                  short_setting = csr_mon.data[PER_W-1:0];
                  head = '0;
                  filled = 0;
               end
               mapt_pkg::CSR_LONG_PERIOD: begin
                  long_setting = csr_mon.data[PER_W-1:0];
                  head = '0;
                  filled = 0;
               end
               mapt_pkg::CSR_SPREAD: begin
                  spread_setting = csr_mon.data;
               end
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_q.insert(expected_q.size(), apply_price(req_mon.price));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $error("result transaction with nothing expected, action %0d", rsp_mon.action);
               errs++;
            end else begin
               want = expected_q[0];
               expected_q.delete(0);
               errs += check_field("action", 64'(want.action), 64'(rsp_mon.action));
               errs += check_field("short_avg", 64'(want.short_avg), 64'(rsp_mon.short_avg));
               errs += check_field("long_avg", 64'(want.long_avg), 64'(rsp_mon.long_avg));
               errs += check_field("balance", {16'd0, want.balance}, {16'd0, rsp_mon.balance});
               errs += check_field("open_count", 64'(want.opens), 64'(rsp_mon.open_count));
               errs += check_field("close_count", 64'(want.closes), 64'(rsp_mon.close_count));
            end
         end
      end
      fail_count <= fail_count + errs;
      pending <= expected_q.size();
   end

endmodule

`default_nettype wire

// ===== sim/moving_average_position_trader_unit_tb.sv =====
// ----------------------------------------------------------------------------
// moving_average_position_trader_unit_tb - top of the trader unit testbench
// drives prices with random gaps, register writes and result back-pressure,
// runs directed crossings and period corner cases, then long random price
// walks over a wide window; the checker beside the block scores results
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_position_trader_unit_tb;

   localparam int PRC_W = mapt_pkg::PRICE_W;
   localparam int PER_W = mapt_pkg::PERIOD_W;
   localparam int IDX_W = mapt_pkg::CSR_IDX_W;
   localparam int DAT_W = mapt_pkg::CSR_DATA_W;
   localparam logic [IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [PRC_W-1:0] PRICE_TOP = '1;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   quiet;
   bit   rsp_hold_req;
   logic [PRC_W-1:0] market_level;

   mapt_req_if req_bus ();
   mapt_rsp_if rsp_bus ();
   mapt_csr_if csr_bus ();

   moving_average_position_trader_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   trade_result_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_hold_req = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic [PRC_W-1:0] pick_price();
      int unsigned roll;

      roll = $urandom_range(0, 19);
      if (roll == 0) return ($urandom_range(0, 1) == 1) ? PRICE_TOP : '0;
      if (roll < 4) return $urandom();
      market_level = market_level + $urandom_range(0, 4000) - 32'd2000;
      return market_level;
   endfunction

   function automatic logic [DAT_W-1:0] period_word(input logic [PER_W-1:0] len);
      logic [DAT_W-1:0] w;

      w = $urandom();
      w[PER_W-1:0] = len;
      return w;
   endfunction

   task automatic send_price(input logic [PRC_W-1:0] p);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.price <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // stop offering prices and wait until the block has drained
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_prices(input int count, input int hold_at, input int pause_at);
      int i;

      for (i = 0; i < count; i++) begin
         if (i == hold_at) rsp_hold_req = 1'b1;
         if (i == pause_at) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_price(pick_price());
      end
   endtask

   task automatic run_phase(input logic [PER_W-1:0] short_len,
                            input logic [PER_W-1:0] long_len,
                            input logic [DAT_W-1:0] spread, input int count);
      settle();
      write_reg(mapt_pkg::CSR_SHORT_PERIOD, period_word(short_len));
      write_reg(mapt_pkg::CSR_LONG_PERIOD, period_word(long_len));
      write_reg(mapt_pkg::CSR_SPREAD, spread);
      market_level = $urandom();
      run_prices(count, -1, -1);
   endtask

   initial begin
      quiet = 1'b0;
      rsp_hold_req = 1'b0;
      market_level = $urandom();
      req_bus.valid <= 1'b0;
      req_bus.price <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset periods, single-entry averages
      send_price('0);
      send_price(PRICE_TOP);
      send_price('0);

      // short average rising above the price closes, spread taken off
      settle();
      write_reg(mapt_pkg::CSR_SHORT_PERIOD, period_word(11'd3));
      write_reg(mapt_pkg::CSR_LONG_PERIOD, period_word(11'd5));
      write_reg(mapt_pkg::CSR_SPREAD, 32'd7);
      write_reg(CSR_UNUSED_INDEX, $urandom());
      send_price(32'd1000); send_price(32'd1000); send_price(32'd400); send_price(32'd400);
      send_price(PRICE_TOP); send_price(PRICE_TOP); send_price('0); send_price('0);
      send_price(32'd5); send_price(32'd6); send_price(32'd7); send_price(32'd8);

      // zero periods read as one
      settle();
      write_reg(mapt_pkg::CSR_SHORT_PERIOD, period_word(11'd0));
      write_reg(mapt_pkg::CSR_LONG_PERIOD, period_word(11'd0));
      write_reg(mapt_pkg::CSR_SPREAD, '1);
      send_price(PRICE_TOP); send_price('0); send_price(32'd123);

      // oversized periods clamp to the window depth
      settle();
      write_reg(mapt_pkg::CSR_SHORT_PERIOD, period_word(11'd2047));
      write_reg(mapt_pkg::CSR_LONG_PERIOD, period_word(11'd2047));
      write_reg(mapt_pkg::CSR_SPREAD, '0);
      send_price(PRICE_TOP); send_price(PRICE_TOP); send_price('0);
      send_price(32'd1); send_price(32'd2);

      run_phase(11'd3, 11'd8, $urandom(), 30);
      run_phase(11'd9, 11'd4, '0, 30);
      run_phase(11'd1024, 11'd1024, '1, 30);
      run_phase(11'($urandom_range(1, 6)), 11'($urandom_range(1, 30)),
                32'($urandom_range(0, 1000)), 30);

      // widest window, partly filled over several spread settings
      run_phase(11'($urandom_range(2, 16)), 11'd2047, $urandom(), 0);
      run_prices(165, 40, -1);
      settle();
      write_reg(mapt_pkg::CSR_SPREAD, '0);
      run_prices(165, -1, 100);
      settle();
      write_reg(mapt_pkg::CSR_SPREAD, 32'($urandom_range(0, 5000)));
      run_prices(165, -1, -1);
      settle();
      write_reg(mapt_pkg::CSR_SPREAD, '1);
      quiet = 1'b1;
      run_prices(165, -1, -1);

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
